// ===== rtl/sosd_pkg.sv =====
// ----------------------------------------------------------------------------
// sosd_pkg
// Shared types and constants of the sound onset / silence detector.
// ----------------------------------------------------------------------------
package sosd_pkg;

  // Sample, gate, level, count and code widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = SampleW + 1;
  localparam int unsigned GateW   = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CodeW   = 2;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned InDataW  = 2 * SampleW;
  localparam int unsigned OutBitsW = CodeW + LevelW + CountW;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NOISE_GATE    = 2'd0,
    REG_SOUND_GATE    = 2'd1,
    REG_SILENCE_LIMIT = 2'd2
  } cfg_reg_e;

  localparam logic [GateW-1:0]  NoiseGateRst    = 16'd500;
  localparam logic [GateW-1:0]  SoundGateRst    = 16'd1000;
  localparam logic [CountW-1:0] SilenceLimitRst = 16'd100;

  // Detector states, also the reported code
  typedef enum logic [CodeW-1:0] {
    ST_IDLE     = 2'd0,
    ST_ONSET    = 2'd1,
    ST_SOUNDING = 2'd2,
    ST_SILENCE  = 2'd3
  } det_state_e;

endpackage

// ===== rtl/sound_onset_silence_detector_core.sv =====
// ----------------------------------------------------------------------------
// sound_onset_silence_detector_core
// Block-energy onset and silence detector for stereo 16-bit frames.
// ----------------------------------------------------------------------------
// One stereo frame is taken per beat, one beat per cycle. Frames are summed
// as absolute values; after every FRAMES_PER_BLOCK frames the block sum is
// divided by twice the frame count (reciprocal multiply) and the detector is
// stepped, giving one result beat per block and none for the other frames.
// After the last frame of its block the result is registered in the
// accumulator, then in the divider multiply, then in the detector step.
// Every stage moves together and holds only while a result beat waits on
// the output, so the sustained rate is one frame per cycle. Configuration
// writes take effect at once and must be made while idle.
module sound_onset_silence_detector_core #(
  parameter int unsigned FRAMES_PER_BLOCK = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [sosd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sosd_pkg::CfgDataW-1:0]   cfg_data_i,
  // Frame stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] left_sample, [31:16] right_sample
  input  logic [sosd_pkg::InDataW-1:0]    s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] detector_code, [17:2] block_level, [33:18] quiet_blocks, rest zero
  output logic [sosd_pkg::OutDataW-1:0]   m_axis_tdata
);
  import sosd_pkg::*;

  // Derived sizes
  localparam int unsigned SumW    = $clog2(65536 * FRAMES_PER_BLOCK + 1);
  localparam int unsigned FrmW    = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
  localparam int unsigned Divisor = 2 * FRAMES_PER_BLOCK;
  localparam int unsigned DivLog  = $clog2(Divisor);
  localparam int unsigned Shift   = SumW + DivLog;
  localparam int unsigned RecipW  = Shift - DivLog + 1;
  localparam logic [63:0] RecipFull =
      ((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];
  localparam logic [FrmW-1:0] LastFrame = FrmW'(FRAMES_PER_BLOCK - 1);

  // Configuration registers
  logic [GateW-1:0]  noise_gate_q, sound_gate_q;
  logic [CountW-1:0] silence_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_gate_q    <= NoiseGateRst;
      sound_gate_q    <= SoundGateRst;
      silence_limit_q <= SilenceLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOISE_GATE:    noise_gate_q    <= cfg_data_i[GateW-1:0];
        REG_SOUND_GATE:    sound_gate_q    <= cfg_data_i[GateW-1:0];
        REG_SILENCE_LIMIT: silence_limit_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: all stages advance together unless a result beat waits
  logic adv, accept;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Absolute sample values
  logic [SampleW-1:0] left_s, right_s;
  logic [MagW-1:0]    left_ext, right_ext, left_mag, right_mag;
  assign left_s    = s_axis_tdata[SampleW-1:0];
  assign right_s   = s_axis_tdata[2*SampleW-1:SampleW];
  assign left_ext  = {left_s[SampleW-1], left_s};
  assign right_ext = {right_s[SampleW-1], right_s};
  assign left_mag  = left_s[SampleW-1]  ? (MagW'(0) - left_ext)  : left_ext;
  assign right_mag = right_s[SampleW-1] ? (MagW'(0) - right_ext) : right_ext;

  // Accumulate one block
  logic [SumW-1:0] sum_q, sum_d, blk_sum_q;
  logic [FrmW-1:0] frame_q;
  logic            blk_valid_q, last_frame;

  assign sum_d      = sum_q + SumW'(left_mag) + SumW'(right_mag);
  assign last_frame = (frame_q == LastFrame);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      frame_q     <= '0;
      blk_valid_q <= 1'b0;
    end else if (adv) begin
      blk_valid_q <= accept && last_frame;
      if (accept) begin
        sum_q   <= last_frame ? '0 : sum_d;
        frame_q <= last_frame ? '0 : frame_q + FrmW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_frame) begin
      blk_sum_q <= sum_d;
    end
  end

  // Divide the block sum by twice the frame count
  logic [SumW+RecipW-1:0] prod;
  logic [LevelW-1:0]      level_q;
  logic                   lvl_valid_q;

  assign prod = SumW'(blk_sum_q) * Recip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= 1'b0;
    end else if (adv) begin
      lvl_valid_q <= blk_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && blk_valid_q) begin
      level_q <= prod[Shift +: LevelW];
    end
  end

  // Detector step: next state
  det_state_e        det_q, det_d, det_base;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              is_quiet, is_loud;

  assign is_quiet = (level_q < noise_gate_q);
  assign is_loud  = (level_q > sound_gate_q);

  always_comb begin
    case (det_q)
      ST_ONSET:   det_base = ST_SOUNDING;
      ST_SILENCE: det_base = ST_IDLE;
      default:    det_base = det_q;
    endcase
    det_d = det_base;
    case (det_base)
      ST_SOUNDING: begin
        if (is_quiet && !(cnt_q < silence_limit_q)) det_d = ST_SILENCE;
      end
      ST_IDLE: begin
        if (is_loud) det_d = ST_ONSET;
      end
      default: det_d = det_base;
    endcase
  end

  // Detector step: quiet block count
  always_comb begin
    cnt_d = cnt_q;
    case (det_base)
      ST_SOUNDING: begin
        if (is_quiet) begin
          cnt_d = (cnt_q < silence_limit_q) ? cnt_q + CountW'(1) : '0;
        end
        if (cnt_d != '0 && is_loud) cnt_d = '0;
      end
      ST_IDLE: begin
        if (is_loud) cnt_d = '0;
      end
      default: cnt_d = cnt_q;
    endcase
  end

  // Detector registers and result beat
  logic               out_valid_q;
  logic [LevelW-1:0]  out_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q       <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= lvl_valid_q;
      if (lvl_valid_q) begin
        det_q <= det_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && lvl_valid_q) begin
      out_level_q <= level_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutBitsW){1'b0}}, cnt_q, out_level_q, det_q};

  // Checks
  a_onset_one_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && lvl_valid_q && det_q == ST_ONSET) |=> det_q != ST_ONSET)
    else $error("onset lasted more than one block");

  a_silence_one_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && lvl_valid_q && det_q == ST_SILENCE) |=> det_q != ST_SILENCE)
    else $error("silence found lasted more than one block");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (det_q == ST_ONSET || det_q == ST_SILENCE) |-> cnt_q == '0)
    else $error("quiet count not cleared on state change");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q <= LastFrame)
    else $error("frame index beyond block length");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sound onset / silence detector core.
// ----------------------------------------------------------------------------
// Stereo frames are queued by the stimulus process and driven one beat at a
// time. Each accepted frame is fed to a bit-true detector model kept here,
// and every completed block leaves one due report. The result monitor pops
// the oldest due report on each result beat and compares it field by field.
// Gates and the silence limit are rewritten between phases while the core is
// idle, and both stream sides idle or stall at random in varying amounts.
// ----------------------------------------------------------------------------
module testbench;
  import sosd_pkg::*;

  localparam int unsigned FramesPerBlock = 8;
  localparam time         ClkPeriod      = 12ns;
  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned DrainCycles    = 12;
  localparam int unsigned RxHoldCycles   = 300;
  localparam int unsigned MaxReported    = 10;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [SampleW-1:0] right;
    logic [SampleW-1:0] left;
  } frame_t;

  typedef struct packed {
    det_state_e        code;
    logic [LevelW-1:0] level;
    logic [CountW-1:0] quiet;
  } det_report_t;

  // DUT connections; the inputs are known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Stimulus and expectation stores
  frame_t      pending_frames[$];
  det_report_t due_reports[$];

  // Detector model state and its copy of the registers
  det_state_e          det_state    = ST_IDLE;
  logic [CountW-1:0]   quiet_count  = '0;
  logic [19:0]         level_acc    = '0;
  int unsigned         frames_in_block = 0;
  logic [GateW-1:0]    noise_thresh = NoiseGateRst;
  logic [GateW-1:0]    gate_sound   = SoundGateRst;
  logic [CountW-1:0]   quiet_limit  = SilenceLimitRst;

  // Traffic shaping
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          tx_pause     = 1'b0;
  int unsigned rx_hold_reqs = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  // Bookkeeping
  int unsigned error_count  = 0;
  int unsigned frames_taken = 0;
  int unsigned reports_seen = 0;
  int unsigned code_seen[4] = '{default: 0};
  frame_t      next_frame;

  sound_onset_silence_detector_core #(
    .FRAMES_PER_BLOCK(FramesPerBlock)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Absolute value of a signed sample; the most negative one gives 32768
  function automatic logic [16:0] sample_mag(input logic [SampleW-1:0] s);
    return s[SampleW-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
  endfunction

  // Accumulate one frame; at a block end step the detector and queue a report
  task automatic step_detector_frame(input frame_t f);
    logic [LevelW-1:0] lvl;
    det_report_t       rep;
    level_acc = level_acc + 20'(sample_mag(f.left)) + 20'(sample_mag(f.right));
    frames_in_block++;
    if (frames_in_block == FramesPerBlock) begin
      lvl = LevelW'(level_acc / (2 * FramesPerBlock));
      level_acc = '0;
      frames_in_block = 0;
      // Onset and silence found last one block only
      if (det_state == ST_SILENCE) begin
        det_state = ST_IDLE;
      end else if (det_state == ST_ONSET) begin
        det_state = ST_SOUNDING;
      end
      if (det_state == ST_SOUNDING) begin
        if (lvl < noise_thresh) begin
          if (quiet_count < quiet_limit) begin
            quiet_count = quiet_count + 1'b1;
          end else begin
            det_state = ST_SILENCE;
            quiet_count = '0;
          end
        end
        if (quiet_count != 0 && lvl > gate_sound) begin
          quiet_count = '0;
        end
      end
      if (det_state == ST_IDLE && lvl > gate_sound) begin
        det_state = ST_ONSET;
        quiet_count = '0;
      end
      rep.code  = det_state;
      rep.level = lvl;
      rep.quiet = quiet_count;
      due_reports.push_back(rep);
    end
  endtask

  // Frame driver: advance the offered beat once it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frames_taken++;
        step_detector_frame(frame_t'(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_frames.size() != 0 && !tx_pause &&
            $urandom_range(99) >= tx_idle_pct) begin
          next_frame = pending_frames.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataW'(next_frame);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus process
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_left <= RxHoldCycles;
      rx_hold_seen <= rx_hold_reqs;
    end
  end

  // Result monitor: check each taken beat against the oldest due report
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report(m_axis_tdata);
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_report(input logic [OutDataW-1:0] d);
    det_report_t want;
    logic [CodeW-1:0]  got_code;
    logic [LevelW-1:0] got_level;
    logic [CountW-1:0] got_quiet;
    got_code  = d[CodeW-1:0];
    got_level = d[CodeW +: LevelW];
    got_quiet = d[CodeW+LevelW +: CountW];
    reports_seen++;
    code_seen[got_code]++;
    if (due_reports.size() == 0) begin
      flag_error($sformatf("result beat %h with no report due", d));
    end else begin
      want = due_reports.pop_front();
      if (got_code != want.code) begin
        flag_error($sformatf("result %0d detector_code: expected %0d, got %0d",
                             reports_seen, want.code, got_code));
      end
      if (got_level != want.level) begin
        flag_error($sformatf("result %0d block_level: expected %0d, got %0d",
                             reports_seen, want.level, got_level));
      end
      if (got_quiet != want.quiet) begin
        flag_error($sformatf("result %0d quiet_blocks: expected %0d, got %0d",
                             reports_seen, want.quiet, got_quiet));
      end
    end
  endtask

  // Sample of the given magnitude with a random sign; 32768 and above give 16'h8000
  function automatic logic [SampleW-1:0] signed_sample(input int unsigned mag);
    logic [SampleW-1:0] v;
    if (mag >= 32768) begin
      return 16'h8000;
    end
    v = SampleW'(mag);
    return $urandom_range(1) ? (~v + 1'b1) : v;
  endfunction

  function automatic int unsigned cap_level(input int x);
    return (x < 0) ? 0 : ((x > 32768) ? 32768 : x);
  endfunction

  function automatic int unsigned loud_level();
    return (gate_sound >= 16'd32768) ? 32768 :
           $urandom_range(32768, int'(gate_sound) + 1);
  endfunction

  function automatic int unsigned quiet_level();
    return (noise_thresh == 0) ? 0 :
           $urandom_range(cap_level(int'(noise_thresh) - 1), 0);
  endfunction

  // Level sitting on or just beside one of the gates
  function automatic int unsigned gate_level();
    case ($urandom_range(3))
      0:       return cap_level(int'(noise_thresh));
      1:       return cap_level(int'(noise_thresh) - 1);
      2:       return cap_level(int'(gate_sound));
      default: return cap_level(int'(gate_sound) + 1);
    endcase
  endfunction

  // Queue one block at a fixed level, or of fully random samples
  task automatic push_block(input int unsigned mag, input bit noisy);
    frame_t f;
    for (int i = 0; i < FramesPerBlock; i++) begin
      if (noisy) begin
        f.left  = SampleW'($urandom);
        f.right = SampleW'($urandom);
      end else begin
        f.left  = signed_sample(mag);
        f.right = signed_sample(mag);
      end
      pending_frames.push_back(f);
    end
  endtask

  // Mostly loud-then-quiet episodes whose quiet run exceeds a limit below 8, some noise
  task automatic push_random_frames(input int unsigned budget);
    int unsigned blocks;
    int unsigned loud_n;
    int unsigned quiet_n;
    blocks = 0;
    while (blocks * FramesPerBlock < budget) begin
      if ($urandom_range(99) < 80) begin
        loud_n  = $urandom_range(3, 1);
        quiet_n = (quiet_limit < 8) ? int'(quiet_limit) + $urandom_range(3, 1) :
                  $urandom_range(6, 1);
        repeat (loud_n) push_block(loud_level(), 1'b0);
        for (int q = 0; q < quiet_n; q++) begin
          if (q == quiet_n / 2 && $urandom_range(99) < 30) begin
            push_block($urandom_range(1) ? gate_level() : loud_level(), 1'b0);
          end else begin
            push_block(quiet_level(), 1'b0);
          end
        end
        blocks += loud_n + quiet_n;
      end else begin
        push_block(gate_level(), 1'($urandom_range(1)));
        blocks++;
      end
    end
  endtask

  // Write all three registers, optionally the spare index too, then settle
  task automatic apply_cfg(input logic [GateW-1:0] noise, input logic [GateW-1:0] sound,
                           input logic [CountW-1:0] limit, input bit poke_spare);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NOISE_GATE;
    cfg_data_i <= noise;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SOUND_GATE;
    cfg_data_i <= sound;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SILENCE_LIMIT;
    cfg_data_i <= limit;
    if (poke_spare) begin
      @(posedge clk_i);
      cfg_idx_i  <= RegSpare;
      cfg_data_i <= CfgDataW'($urandom);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    noise_thresh = noise;
    gate_sound   = sound;
    quiet_limit  = limit;
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Hold until every frame is taken and every report has come back
  task automatic wait_drained();
    while (pending_frames.size() != 0 || s_axis_tvalid || due_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    logic [GateW-1:0] rand_noise;
    logic [GateW-1:0] rand_sound;
    frame_t           f;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: full-scale negative block, half-scale block, near-zero block
    f = '{right: 16'h8000, left: 16'h8000};
    repeat (FramesPerBlock) pending_frames.push_back(f);
    f = '{right: 16'h0000, left: 16'h7fff};
    repeat (FramesPerBlock) pending_frames.push_back(f);
    f = '{right: 16'h0001, left: 16'hffff};
    repeat (FramesPerBlock) pending_frames.push_back(f);
    wait_drained();

    // Ordinary gates, short limit, no idling
    apply_cfg(16'd2000, 16'd4000, 16'd2, 1'b0);
    set_idling(0, 0);
    push_random_frames(160);
    wait_drained();

    // Zero silence limit, equal gates, ignored spare register, sender idling
    apply_cfg(16'd3000, 16'd3000, 16'd0, 1'b1);
    set_idling(60, 0);
    push_random_frames(120);
    wait_drained();

    // Gates and limit at full scale, receiver stalling
    apply_cfg(16'hffff, 16'hffff, 16'hffff, 1'b0);
    set_idling(0, 60);
    push_random_frames(64);
    wait_drained();

    // Zero gates, both sides idling
    apply_cfg(16'd0, 16'd0, 16'd1, 1'b0);
    set_idling(32, 32);
    push_random_frames(120);
    wait_drained();

    // Random gates; long receiver hold-off, then a sender pause mid-stream
    rand_noise = GateW'($urandom_range(6000, 0));
    rand_sound = GateW'($urandom_range(12000, int'(rand_noise)));
    apply_cfg(rand_noise, rand_sound, CountW'($urandom_range(4, 0)), 1'b0);
    set_idling(0, 0);
    push_random_frames(160);
    rx_hold_reqs++;
    while (pending_frames.size() > 100) @(negedge clk_i);
    tx_pause = 1'b1;
    while (s_axis_tvalid || due_reports.size() != 0) @(negedge clk_i);
    tx_pause = 1'b0;
    set_idling(32, 32);
    wait_drained();

    if (due_reports.size() != 0) begin
      flag_error($sformatf("%0d reports never arrived", due_reports.size()));
    end
    $display("Run covered %0d frames and %0d block results over six register settings.",
             frames_taken, reports_seen);
    $display("Codes seen: idle %0d, onset %0d, sounding %0d, silence %0d; %0d errors.",
             code_seen[ST_IDLE], code_seen[ST_ONSET], code_seen[ST_SOUNDING],
             code_seen[ST_SILENCE], error_count);
    if (error_count == 0) begin
      $display("PASS sound_onset_silence_detector_core");
    end else begin
      $display("FAIL sound_onset_silence_detector_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(200_000 * ClkPeriod);
    $display("Timed out with %0d frames queued and %0d reports due.",
             pending_frames.size(), due_reports.size());
    $display("FAIL sound_onset_silence_detector_core");
    $finish;
  end

endmodule
